// File: rtl/core/dsus_pkg.sv
// Shared widths, request and status codes for the dual stack with undo store.
`timescale 1ns / 1ps

package dsus_pkg;

	localparam int STORE_DEPTH_DEF = 256;
	localparam int DATA_W          = 32;
	localparam int DEPTH_W         = 9;
	localparam int REQ_W           = 2;
	localparam int STAT_W          = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH    = 2'd0,
		REQ_RESTORE = 2'd1,
		REQ_POP     = 2'd2,
		REQ_MOVE    = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK           = 2'd0,
		ST_MAIN_EMPTY   = 2'd1,
		ST_SECOND_EMPTY = 2'd2,
		ST_FULL         = 2'd3
	} stat_t;

endpackage

// File: rtl/core/dual_stack_with_undo_store_unit.sv
// Top level: main stack and deleted-items stack sharing one store.
//
//  channel  | handshake           | beat
//  ---------+---------------------+---------------------------------------------
//  request  | in_valid / in_stall | req_type, value
//  result   | out_valid/out_stall | status, out_value, main_depth, second_depth
//
// One request per cycle while in_stall is low; its result is registered in
// stage 1, then in the output register. Counters update at the accept edge;
// the store write lands as the request leaves stage 1 and is forwarded to the
// read of the following request. Reset clears the counters and valids only;
// the store needs no clearing pass. A stalled result holds in the output
// register while one more request is taken into the stage behind it.
`timescale 1ns / 1ps

module dual_stack_with_undo_store_unit #(
	parameter int STORE_DEPTH = dsus_pkg::STORE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [dsus_pkg::REQ_W-1:0]           req_type,
	input  logic signed [dsus_pkg::DATA_W-1:0]   value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [dsus_pkg::STAT_W-1:0]          status,
	output logic signed [dsus_pkg::DATA_W-1:0]   out_value,
	output logic [dsus_pkg::DEPTH_W-1:0]         main_depth,
	output logic [dsus_pkg::DEPTH_W-1:0]         second_depth
);
	import dsus_pkg::*;

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam logic [CW:0] DEPTH_C = (CW+1)'(STORE_DEPTH);

	logic [DATA_W-1:0] store_mem [STORE_DEPTH];

	logic [CW-1:0] main_cnt_q, sec_cnt_q;
	logic          valid_s1, out_valid_q;
	logic          in_acc, s1_adv;

	req_t          req;
	stat_t         stat_d;
	logic [CW:0]   total;
	logic [CW-1:0] mc_m1, sc_p1, main_nx, sec_nx;
	logic [CW:0]   top_sec, below_sec;
	logic [AW-1:0] rd_addr_d, wr_addr_d;
	logic          wr_en_d, use_rd_d, byp_hit_d;
	logic [CW+DEPTH_W-1:0] main_ext, sec_ext;

	stat_t             status_s1;
	logic [DATA_W-1:0] value_s1, rd_s1, byp_data_s1, eff_rd, res_s1;
	logic [AW-1:0]     wr_addr_s1;
	logic              wr_en_s1, use_rd_s1, byp_hit_s1;
	logic [DEPTH_W-1:0] main_d_s1, sec_d_s1;

	stat_t             status_q;
	logic [DATA_W-1:0] out_value_q;
	logic [DEPTH_W-1:0] main_depth_q, sec_depth_q;

	assign req       = req_t'(req_type);
	assign s1_adv    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !s1_adv;
	assign in_acc    = in_valid && !in_stall;

	assign total     = {1'b0, main_cnt_q} + {1'b0, sec_cnt_q};
	assign mc_m1     = main_cnt_q - CW'(1);
	assign sc_p1     = sec_cnt_q + CW'(1);
	assign top_sec   = DEPTH_C - {1'b0, sec_cnt_q};
	assign below_sec = DEPTH_C - {1'b0, sc_p1};

	always_comb begin
		stat_d    = ST_OK;
		main_nx   = main_cnt_q;
		sec_nx    = sec_cnt_q;
		wr_en_d   = 1'b0;
		use_rd_d  = 1'b0;
		wr_addr_d = main_cnt_q[AW-1:0];
		rd_addr_d = mc_m1[AW-1:0];
		unique case (req)
			REQ_PUSH: begin
				if (total >= DEPTH_C) begin
					stat_d = ST_FULL;
				end else begin
					wr_en_d = 1'b1;
					main_nx = main_cnt_q + CW'(1);
				end
			end
			REQ_RESTORE: begin
				if (sec_cnt_q == '0) begin
					stat_d = ST_SECOND_EMPTY;
				end else begin
					rd_addr_d = top_sec[AW-1:0];
					use_rd_d  = 1'b1;
					sec_nx    = sec_cnt_q - CW'(1);
					wr_en_d   = 1'b1;
					main_nx   = main_cnt_q + CW'(1);
				end
			end
			REQ_POP: begin
				if (main_cnt_q == '0) begin
					stat_d = ST_MAIN_EMPTY;
				end else begin
					use_rd_d = 1'b1;
					main_nx  = mc_m1;
				end
			end
			REQ_MOVE: begin
				if (main_cnt_q == '0) begin
					stat_d = ST_MAIN_EMPTY;
				end else begin
					use_rd_d  = 1'b1;
					main_nx   = mc_m1;
					sec_nx    = sc_p1;
					wr_en_d   = 1'b1;
					wr_addr_d = below_sec[AW-1:0];
				end
			end
			default: begin
				stat_d = ST_OK;
			end
		endcase
	end

	assign main_ext  = {{DEPTH_W{1'b0}}, main_nx};
	assign sec_ext   = {{DEPTH_W{1'b0}}, sec_nx};
	assign byp_hit_d = s1_adv && wr_en_s1 && (wr_addr_s1 == rd_addr_d);

	assign eff_rd = byp_hit_s1 ? byp_data_s1 : rd_s1;
	assign res_s1 = use_rd_s1 ? eff_rd : value_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_cnt_q  <= '0;
			sec_cnt_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				main_cnt_q <= main_nx;
				sec_cnt_q  <= sec_nx;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && wr_en_s1) begin
			store_mem[wr_addr_s1] <= res_s1;
		end
		if (in_acc) begin
			rd_s1 <= store_mem[rd_addr_d];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_s1   <= stat_d;
			value_s1    <= (req == REQ_PUSH && stat_d == ST_OK) ? value : '0;
			wr_en_s1    <= wr_en_d;
			wr_addr_s1  <= wr_addr_d;
			use_rd_s1   <= use_rd_d;
			byp_hit_s1  <= byp_hit_d;
			byp_data_s1 <= res_s1;
			main_d_s1   <= main_ext[DEPTH_W-1:0];
			sec_d_s1    <= sec_ext[DEPTH_W-1:0];
		end
		if (s1_adv) begin
			status_q     <= status_s1;
			out_value_q  <= res_s1;
			main_depth_q <= main_d_s1;
			sec_depth_q  <= sec_d_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_value    = out_value_q;
	assign main_depth   = main_depth_q;
	assign second_depth = sec_depth_q;

endmodule

// File: rtl/core/dsus_checker.sv
// Port-level checker for the dual stack with undo store, bound to the top level.
`timescale 1ns / 1ps

module dsus_checker #(
	parameter int STORE_DEPTH = dsus_pkg::STORE_DEPTH_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [dsus_pkg::STAT_W-1:0]        status,
	input logic signed [dsus_pkg::DATA_W-1:0] out_value,
	input logic [dsus_pkg::DEPTH_W-1:0]       main_depth,
	input logic [dsus_pkg::DEPTH_W-1:0]       second_depth
);
	import dsus_pkg::*;

	localparam logic [DEPTH_W:0] DEPTH_C = (DEPTH_W+1)'(STORE_DEPTH);
	localparam bit SMALL = (STORE_DEPTH <= 511);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_value)
			&& $stable(main_depth) && $stable(second_depth))
		else $error("result beat changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_value == '0)
		else $error("error beat carries a nonzero value");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		SMALL && out_valid && status == ST_FULL
			|-> ({1'b0, main_depth} + {1'b0, second_depth}) == DEPTH_C)
		else $error("store full reported below capacity");

	a_main_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_MAIN_EMPTY |-> main_depth == '0)
		else $error("main empty reported with items on main stack");

	a_sec_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SECOND_EMPTY |-> second_depth == '0)
		else $error("second empty reported with items on second stack");

endmodule

bind dual_stack_with_undo_store_unit dsus_checker #(
	.STORE_DEPTH(STORE_DEPTH)
) u_dsus_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.out_value    (out_value),
	.main_depth   (main_depth),
	.second_depth (second_depth)
);
